// ===== rtl/pdt_pkg.sv =====
// Shared types and constants for the duplicate packet filter.
package pdt_pkg;

  localparam int unsigned SRC_W  = 16;
  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned OIDX_W = 4;
  localparam int unsigned REC_W  = SRC_W + SEQ_W + TIME_W;

  localparam logic [TIME_W-1:0] TIME_MAX  = 32'hFFFF_FFFF;
  localparam logic [TIME_W-1:0] TTL_RESET = 32'd5000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } pdt_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } pdt_cmd_t;

  typedef struct packed {
    logic eval_hit;
    logic eval_last;
  } pdt_status_t;

endpackage

// ===== rtl/packet_dedup_table_ttl_lru.sv =====
// Top level of the duplicate packet filter with TTL ageing and oldest-entry replacement.
//
// A request is taken when start is high and busy is low. The block scans the ENTRIES
// records of its table one per cycle through a single registered-read memory port,
// stopping at the first live record with the same source, then writes the chosen record
// in the commit state. The result appears on out_is_duplicate and out_entry_index with
// out_valid high for exactly one cycle after the commit state; it must be taken in that
// cycle, since the block has no way to hold it. busy is low again in the cycle the
// result is shown, so a new request may be accepted there. The table is empty after
// reset with no clearing pass, and the TTL ttl_r (cfg_wdata) resets to 5000 ticks.
module packet_dedup_table_ttl_lru
  import pdt_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [SRC_W-1:0]  in_source_id,
  input  logic [SEQ_W-1:0]  in_sequence_number,
  input  logic [TIME_W-1:0] in_now_tick,
  output logic              out_valid,
  output logic              out_is_duplicate,
  output logic [OIDX_W-1:0] out_entry_index,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata
);

  pdt_cmd_t    cmd;
  pdt_status_t st;

  pdt_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .st   (st),
    .cmd  (cmd),
    .busy (busy)
  );

  pdt_dp #(
    .ENTRIES(ENTRIES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_source_id      (in_source_id),
    .in_sequence_number(in_sequence_number),
    .in_now_tick       (in_now_tick),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_is_duplicate  (out_is_duplicate),
    .out_entry_index   (out_entry_index)
  );

  // Every accepted request keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // A result is only shown once the block has returned to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Leaving the busy phase always delivers exactly one result.
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("request finished without a result");

  // Results are single-cycle strobes and never come back to back.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

endmodule

// ===== rtl/pdt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pdt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/pdt_ctrl.sv =====
// Controller state machine: idle, table scan, commit of the chosen entry.
module pdt_ctrl
  import pdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  pdt_status_t st,
  output pdt_cmd_t    cmd,
  output logic        busy
);

  pdt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        // A matching source ends the scan early; otherwise run to the last entry.
        if (st.eval_hit || st.eval_last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== rtl/pdt_dp.sv =====
// Datapath: request registers, table memory, valid bits, scan and victim selection.
module pdt_dp
  import pdt_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pdt_cmd_t          cmd,
  output pdt_status_t       st,
  input  logic [SRC_W-1:0]  in_source_id,
  input  logic [SEQ_W-1:0]  in_sequence_number,
  input  logic [TIME_W-1:0] in_now_tick,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata,
  output logic              out_valid,
  output logic              out_is_duplicate,
  output logic [OIDX_W-1:0] out_entry_index
);

  localparam int unsigned IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

  logic [TIME_W-1:0] ttl_r;
  logic [SRC_W-1:0]  src_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [TIME_W-1:0] now_r;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [IDXW-1:0]    rd_idx_r, rd_idx_nxt;
  logic               iss_pend_r, iss_pend_nxt;
  logic               proc_vld_r, proc_vld_nxt;
  logic [IDXW-1:0]    proc_idx_r, proc_idx_nxt;
  logic [IDXW-1:0]    victim_r, victim_nxt;
  logic [TIME_W-1:0]  oldest_r, oldest_nxt;
  logic               have_free_r, have_free_nxt;
  logic               hit_r, hit_nxt;
  logic               dup_r, dup_nxt;

  logic               out_valid_r;
  logic               out_dup_r;
  logic [OIDX_W-1:0]  out_idx_r;

  logic               rd_en;
  logic [REC_W-1:0]   rdata;
  logic [SRC_W-1:0]   e_src;
  logic [SEQ_W-1:0]   e_seq;
  logic [TIME_W-1:0]  e_time;
  logic [TIME_W-1:0]  age;
  logic               eval;
  logic               e_valid;
  logic               expire;
  logic               hit;
  logic [IDXW+OIDX_W-1:0] victim_ext;

  pdt_ram #(
    .WIDTH(REC_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.commit),
    .waddr(victim_r),
    .wdata({src_r, seq_r, now_r}),
    .re   (rd_en),
    .raddr(rd_idx_r),
    .rdata(rdata)
  );

  assign e_src  = rdata[REC_W-1 -: SRC_W];
  assign e_seq  = rdata[TIME_W +: SEQ_W];
  assign e_time = rdata[TIME_W-1:0];

  // Age wraps modulo 2^32 like the tick itself.
  assign age     = now_r - e_time;
  assign eval    = cmd.scan && proc_vld_r;
  assign e_valid = valid_r[proc_idx_r];
  assign expire  = e_valid && (age > ttl_r);
  assign hit     = e_valid && !expire && (e_src == src_r);

  assign st.eval_hit  = eval && hit;
  assign st.eval_last = eval && (proc_idx_r == LAST_IDX);

  assign rd_en = cmd.scan && iss_pend_r;

  always_comb begin
    rd_idx_nxt    = rd_idx_r;
    iss_pend_nxt  = iss_pend_r;
    proc_vld_nxt  = 1'b0;
    proc_idx_nxt  = proc_idx_r;
    valid_nxt     = valid_r;
    victim_nxt    = victim_r;
    oldest_nxt    = oldest_r;
    have_free_nxt = have_free_r;
    hit_nxt       = hit_r;
    dup_nxt       = dup_r;

    if (cmd.load) begin
      rd_idx_nxt    = '0;
      iss_pend_nxt  = 1'b1;
      victim_nxt    = '0;
      oldest_nxt    = TIME_MAX;
      have_free_nxt = 1'b0;
      hit_nxt       = 1'b0;
      dup_nxt       = 1'b0;
    end

    // Read issue runs one entry ahead of evaluation.
    if (rd_en) begin
      proc_vld_nxt = 1'b1;
      proc_idx_nxt = rd_idx_r;
      if (rd_idx_r == LAST_IDX) begin
        iss_pend_nxt = 1'b0;
      end else begin
        rd_idx_nxt = rd_idx_r + IDXW'(1);
      end
    end

    if (eval) begin
      if (e_valid) begin
        if (expire) begin
          valid_nxt[proc_idx_r] = 1'b0;
          if (!have_free_r) begin
            victim_nxt    = proc_idx_r;
            have_free_nxt = 1'b1;
          end
        end else if (hit) begin
          victim_nxt = proc_idx_r;
          hit_nxt    = 1'b1;
          dup_nxt    = (e_seq == seq_r);
        end else if (!have_free_r && (e_time < oldest_r)) begin
          oldest_nxt = e_time;
          victim_nxt = proc_idx_r;
        end
      end else if (!have_free_r) begin
        victim_nxt    = proc_idx_r;
        have_free_nxt = 1'b1;
      end
    end

    if (cmd.commit) begin
      valid_nxt[victim_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r       <= TTL_RESET;
      valid_r     <= '0;
      iss_pend_r  <= 1'b0;
      proc_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        ttl_r <= cfg_wdata;
      end
      valid_r     <= valid_nxt;
      iss_pend_r  <= iss_pend_nxt;
      proc_vld_r  <= proc_vld_nxt;
      out_valid_r <= cmd.commit;
    end
  end

  assign victim_ext = {{OIDX_W{1'b0}}, victim_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_r <= in_source_id;
      seq_r <= in_sequence_number;
      now_r <= in_now_tick;
    end
    rd_idx_r    <= rd_idx_nxt;
    proc_idx_r  <= proc_idx_nxt;
    victim_r    <= victim_nxt;
    oldest_r    <= oldest_nxt;
    have_free_r <= have_free_nxt;
    hit_r       <= hit_nxt;
    dup_r       <= dup_nxt;
    if (cmd.commit) begin
      out_dup_r <= hit_r && dup_r;
      out_idx_r <= victim_ext[OIDX_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_duplicate = out_dup_r;
  assign out_entry_index  = out_idx_r;

endmodule
